// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the forwarding table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/nft_pkg.sv =====
// Package with types, constants and helper functions of the forwarding table.
`timescale 1ns / 1ps
`default_nettype none

package nft_pkg;

  localparam int MAX_DIGITS      = 16;
  localparam int NUM_MAPS_DEF    = 4;
  localparam int NUM_ENTRIES_DEF = 64;
  localparam int NIBBLES         = 16;
  localparam int DIGITS_W        = 4 * NIBBLES;
  localparam int LEN_W           = 5;
  localparam int SLOT_W          = 2;
  localparam logic [3:0] DIGIT_MAX = 4'd9;

  typedef enum logic [2:0] {
    MODE_CREATE    = 3'd0,
    MODE_DELETE    = 3'd1,
    MODE_INSERT    = 3'd2,
    MODE_ERASE     = 3'd3,
    MODE_TRANSFORM = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NO_MAP      = 3'd1,
    ST_BAD_NUM     = 3'd2,
    ST_FULL        = 3'd3,
    ST_NO_FREE_MAP = 3'd4
  } status_t;

  // Which fields a result carries besides its status.
  typedef enum logic [2:0] {
    RK_NONE,
    RK_CREATE,
    RK_CUR,
    RK_START,
    RK_ERASED
  } res_kind_t;

  typedef struct packed {
    logic [2:0]          mode;
    logic [SLOT_W-1:0]   map_slot;
    logic [DIGITS_W-1:0] src_digits;
    logic [LEN_W-1:0]    src_len;
    logic [DIGITS_W-1:0] dst_digits;
    logic [LEN_W-1:0]    dst_len;
  } req_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   new_map_slot;
    logic [DIGITS_W-1:0] result_digits;
    logic [LEN_W-1:0]    result_len;
    logic                was_erased;
    logic                cycle_found;
    logic [2:0]          status;
  } rsp_t;

  // One entry of the shared store.
  typedef struct packed {
    logic [SLOT_W-1:0]   owner;
    logic [DIGITS_W-1:0] key;
    logic [LEN_W-1:0]    key_len;
    logic [DIGITS_W-1:0] value;
    logic [LEN_W-1:0]    value_len;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      cap;
    logic      map_create;
    logic      map_delete;
    logic      trans_init;
    logic      scan_clr;
    logic      scan_run;
    logic      advance;
    logic      ent_write;
    logic      ent_erase;
    logic      res_set;
    res_kind_t res_kind;
    status_t   res_status;
    logic      out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] mode;
    logic       live;
    logic       src_ok;
    logic       dst_ok;
    logic       map_free_any;
    logic       scan_done;
    logic       found;
    logic       free_found;
    logic       hit_visited;
    logic       out_busy;
  } sts_t;

  // Zero every nibble at or above the digit count.
  function automatic logic [DIGITS_W-1:0] mask_digits(input logic [DIGITS_W-1:0] digits,
                                                      input logic [LEN_W-1:0] len);
    logic [DIGITS_W-1:0] m;
    m = '0;
    for (int i = 0; i < NIBBLES; i++) begin
      if (LEN_W'(i) < len) begin
        m[4*i +: 4] = digits[4*i +: 4];
      end
    end
    return m;
  endfunction

  // A number is valid with 1 to MAX_DIGITS digits, each of them 0 to 9.
  function automatic logic number_ok(input logic [DIGITS_W-1:0] digits,
                                     input logic [LEN_W-1:0] len);
    logic ok;
    ok = (len != '0) && (len <= LEN_W'(MAX_DIGITS));
    for (int i = 0; i < NIBBLES; i++) begin
      if (LEN_W'(i) < len && digits[4*i +: 4] > DIGIT_MAX) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/nft_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module nft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/nft_ctrl.sv =====
// Controller state machine of the forwarding table.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module nft_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  nft_pkg::sts_t sts,
  output nft_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_POST,
    S_FIN
  } state_t;

  state_t state, state_next;

  // No transfer is taken while reset is held.
  assign req_ready = (state == S_IDLE) && !rst;

  // Next state and commands.
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid && req_ready) begin
          cmd.cap    = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.res_kind   = nft_pkg::RK_NONE;
        cmd.res_status = nft_pkg::ST_OK;
        state_next     = S_FIN;
        unique case (sts.mode)
          nft_pkg::MODE_CREATE: begin
            cmd.res_set    = 1'b1;
            cmd.res_kind   = nft_pkg::RK_CREATE;
            cmd.res_status = sts.map_free_any ? nft_pkg::ST_OK : nft_pkg::ST_NO_FREE_MAP;
            cmd.map_create = sts.map_free_any;
          end
          nft_pkg::MODE_DELETE, nft_pkg::MODE_INSERT, nft_pkg::MODE_ERASE,
          nft_pkg::MODE_TRANSFORM: begin
            if (!sts.live) begin
              cmd.res_set    = 1'b1;
              cmd.res_status = nft_pkg::ST_NO_MAP;
            end else if (sts.mode == nft_pkg::MODE_DELETE) begin
              cmd.map_delete = 1'b1;
              cmd.scan_clr   = 1'b1;
              state_next     = S_SCAN;
            end else if (!sts.src_ok ||
                         (sts.mode == nft_pkg::MODE_INSERT && !sts.dst_ok)) begin
              cmd.res_set    = 1'b1;
              cmd.res_status = nft_pkg::ST_BAD_NUM;
            end else begin
              cmd.trans_init = 1'b1;
              cmd.scan_clr   = 1'b1;
              state_next     = S_SCAN;
            end
          end
          default: begin
            cmd.res_set = 1'b1;
          end
        endcase
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_done) begin
          state_next = S_POST;
        end
      end
      S_POST: begin
        cmd.res_set    = 1'b1;
        cmd.res_kind   = nft_pkg::RK_NONE;
        cmd.res_status = nft_pkg::ST_OK;
        state_next     = S_FIN;
        unique case (sts.mode)
          nft_pkg::MODE_INSERT: begin
            if (sts.found || sts.free_found) begin
              cmd.ent_write = 1'b1;
            end else begin
              cmd.res_status = nft_pkg::ST_FULL;
            end
          end
          nft_pkg::MODE_ERASE: begin
            if (sts.found) begin
              cmd.ent_erase = 1'b1;
              cmd.res_kind  = nft_pkg::RK_ERASED;
            end
          end
          nft_pkg::MODE_TRANSFORM: begin
            if (!sts.found) begin
              cmd.res_kind = nft_pkg::RK_CUR;
            end else if (sts.hit_visited) begin
              cmd.res_kind = nft_pkg::RK_START;
            end else begin
              // Follow one more link of the chain.
              cmd.res_set  = 1'b0;
              cmd.advance  = 1'b1;
              cmd.scan_clr = 1'b1;
              state_next   = S_SCAN;
            end
          end
          default: begin
            cmd.res_kind = nft_pkg::RK_NONE;
          end
        endcase
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `ASSERT_NEXT(a_one_item, req_valid && req_ready, !req_ready, "second transfer while busy")
  `ASSERT_IMPL(a_ready_idle, req_ready, state == S_IDLE, "ready outside idle")
  `ASSERT_NEXT(a_load_returns, cmd.out_load, state == S_IDLE, "no return to idle after a result")

endmodule

`default_nettype wire

// ===== hw/rtl/nft_datapath.sv =====
// Datapath of the forwarding table: map flags, entry store, scan logic and result.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module nft_datapath #(
  parameter int NUM_MAPS    = nft_pkg::NUM_MAPS_DEF,
  parameter int NUM_ENTRIES = nft_pkg::NUM_ENTRIES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  nft_pkg::req_t req,
  input  nft_pkg::cmd_t cmd,
  output nft_pkg::sts_t sts,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output nft_pkg::rsp_t rsp
);

  localparam int IW = $clog2(NUM_ENTRIES);
  localparam int SW = $clog2(NUM_ENTRIES + 1);

  // Item held for the whole operation.
  logic [2:0]                   mode;
  logic [nft_pkg::SLOT_W-1:0]   slot;
  logic [nft_pkg::DIGITS_W-1:0] src, dst, cur;
  logic [nft_pkg::LEN_W-1:0]    slen, dlen, clen;

  // Control state.
  logic [NUM_MAPS-1:0]    map_live;
  logic [NUM_ENTRIES-1:0] used;
  logic [NUM_ENTRIES-1:0] visited;
  logic [SW-1:0]          scan_i;
  logic                   rd_v;
  logic                   found;
  logic                   free_found;
  logic                   had_prev;

  // Scan results.
  logic [IW-1:0]                rd_idx, hit_idx, free_idx, prev_idx;
  logic [nft_pkg::DIGITS_W-1:0] hit_val;
  logic [nft_pkg::LEN_W-1:0]    hit_len;
  nft_pkg::rsp_t                res;
  nft_pkg::rsp_t                res_next;

  // Store ports.
  logic            we;
  logic [IW-1:0]   waddr, raddr;
  nft_pkg::entry_t wdata, rdata;

  logic                       live, map_any, own, match;
  logic [nft_pkg::SLOT_W-1:0] map_idx;

  // Map lookup and lowest free map.
  always_comb begin
    live    = 1'b0;
    map_any = 1'b0;
    map_idx = '0;
    for (int m = 0; m < NUM_MAPS; m++) begin
      if (int'(slot) == m && map_live[m]) begin
        live = 1'b1;
      end
    end
    for (int m = NUM_MAPS - 1; m >= 0; m--) begin
      if (!map_live[m]) begin
        map_any = 1'b1;
        map_idx = nft_pkg::SLOT_W'(m);
      end
    end
  end

  // Compare of the entry read in the previous cycle.
  assign own   = rd_v && used[rd_idx] && (rdata.owner == slot);
  assign match = own && (rdata.key_len == clen) && (rdata.key == cur);

  assign raddr = scan_i[IW-1:0];
  assign we    = cmd.ent_write;
  assign waddr = found ? hit_idx : free_idx;
  assign wdata = '{owner: slot, key: src, key_len: slen, value: dst, value_len: dlen};

  nft_ram #(
    .WIDTH ($bits(nft_pkg::entry_t)),
    .DEPTH (NUM_ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Status toward the controller.
  always_comb begin
    sts.mode         = mode;
    sts.live         = live;
    sts.src_ok       = nft_pkg::number_ok(src, slen);
    sts.dst_ok       = nft_pkg::number_ok(dst, dlen);
    sts.map_free_any = map_any;
    sts.scan_done    = (scan_i == SW'(NUM_ENTRIES)) && !rd_v;
    sts.found        = found;
    sts.free_found   = free_found;
    sts.hit_visited  = visited[hit_idx];
    sts.out_busy     = rsp_valid && !rsp_ready;
  end

  // Result fields selected by the controller.
  always_comb begin
    res_next        = '0;
    res_next.status = cmd.res_status;
    case (cmd.res_kind)
      nft_pkg::RK_CREATE: res_next.new_map_slot = map_idx;
      nft_pkg::RK_CUR: begin
        res_next.result_digits = cur;
        res_next.result_len    = clen;
      end
      nft_pkg::RK_START: begin
        res_next.result_digits = src;
        res_next.result_len    = slen;
        res_next.cycle_found   = 1'b1;
      end
      nft_pkg::RK_ERASED: res_next.was_erased = 1'b1;
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      map_live   <= '0;
      used       <= '0;
      visited    <= '0;
      scan_i     <= '0;
      rd_v       <= 1'b0;
      found      <= 1'b0;
      free_found <= 1'b0;
      had_prev   <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      for (int m = 0; m < NUM_MAPS; m++) begin
        if (cmd.map_create && map_idx == nft_pkg::SLOT_W'(m)) begin
          map_live[m] <= 1'b1;
        end
        if (cmd.map_delete && int'(slot) == m) begin
          map_live[m] <= 1'b0;
        end
      end
      if (cmd.trans_init) begin
        visited  <= '0;
        had_prev <= 1'b0;
      end
      if (cmd.scan_run) begin
        if (scan_i < SW'(NUM_ENTRIES)) begin
          scan_i <= scan_i + 1'b1;
          rd_v   <= 1'b1;
        end else begin
          rd_v <= 1'b0;
        end
        if (match && !found) begin
          found <= 1'b1;
        end
        if (rd_v && !used[rd_idx] && !free_found) begin
          free_found <= 1'b1;
        end
        // Delete sweep drops every entry of the map.
        if (own && mode == nft_pkg::MODE_DELETE) begin
          used[rd_idx] <= 1'b0;
        end
      end
      if (cmd.advance) begin
        if (had_prev) begin
          visited[prev_idx] <= 1'b1;
        end
        had_prev <= 1'b1;
      end
      if (cmd.scan_clr) begin
        scan_i     <= '0;
        rd_v       <= 1'b0;
        found      <= 1'b0;
        free_found <= 1'b0;
      end
      if (cmd.ent_write) begin
        used[waddr] <= 1'b1;
      end
      if (cmd.ent_erase) begin
        used[hit_idx] <= 1'b0;
      end
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      mode <= req.mode;
      slot <= req.map_slot;
      src  <= nft_pkg::mask_digits(req.src_digits, req.src_len);
      slen <= req.src_len;
      dst  <= nft_pkg::mask_digits(req.dst_digits, req.dst_len);
      dlen <= req.dst_len;
    end
    if (cmd.trans_init) begin
      cur  <= src;
      clen <= slen;
    end
    if (cmd.scan_run) begin
      rd_idx <= scan_i[IW-1:0];
      if (match && !found) begin
        hit_idx <= rd_idx;
        hit_val <= rdata.value;
        hit_len <= rdata.value_len;
      end
      if (rd_v && !used[rd_idx] && !free_found) begin
        free_idx <= rd_idx;
      end
    end
    if (cmd.advance) begin
      prev_idx <= hit_idx;
      cur      <= hit_val;
      clen     <= hit_len;
    end
    // Result assembly.
    if (cmd.res_set) begin
      res <= res_next;
    end
    if (cmd.out_load) begin
      rsp <= res;
    end
  end

  `ASSERT_IMPL(a_write_target, cmd.ent_write, found || free_found, "insert without a target")
  `ASSERT_IMPL(a_no_overrun, cmd.out_load, !(rsp_valid && !rsp_ready), "result overwritten")
  `ASSERT_ALWAYS(a_scan_bound, scan_i <= SW'(NUM_ENTRIES), "scan ran past the store")

endmodule

`default_nettype wire

// ===== hw/rtl/number_forwarding_table_unit.sv =====
// Top level of the number forwarding table: controller, datapath and entry store.
// Usage:
//  - Requests arrive on req (valid/ready); each transfer carries mode, map slot,
//    source and destination numbers as BCD digits with lengths.
//  - Exactly one response per request leaves on rsp (valid/ready).
//  - One request is worked on at a time; req_ready is high only when idle.
//  - Create and any request rejected by a check finish without a sweep of the store.
//  - Delete, insert and erase each sweep the entry store once, reading one entry
//    per cycle through its single read port.
//  - Transform sweeps the store once per link followed and once more for the
//    final lookup.
//  - The response register holds a result while the receiver stalls; the next
//    request may be taken then, and its result waits until the register drains.
//  - Reset clears all map flags and entry used flags; no sweep of the store
//    follows, and the first request can be taken right after reset.
`timescale 1ns / 1ps
`default_nettype none

module number_forwarding_table_unit #(
  parameter int NUM_MAPS    = nft_pkg::NUM_MAPS_DEF,
  parameter int NUM_ENTRIES = nft_pkg::NUM_ENTRIES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  nft_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output nft_pkg::rsp_t rsp
);

  nft_pkg::cmd_t cmd;
  nft_pkg::sts_t sts;

  nft_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  nft_datapath #(
    .NUM_MAPS    (NUM_MAPS),
    .NUM_ENTRIES (NUM_ENTRIES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking testbench of the number forwarding table unit.
`timescale 1ns / 1ps

module tb_top;

  localparam int N_MAPS    = 4;
  localparam int N_ENTRIES = 64;
  localparam int N_RANDOM  = 1950;
  localparam int QUIET_TAIL = 200;
  localparam longint CYCLE_LIMIT = 40000000;
  localparam int SW = nft_pkg::SLOT_W;
  localparam int DW = nft_pkg::DIGITS_W;
  localparam int LW = nft_pkg::LEN_W;

  typedef struct {
    nft_pkg::req_t r;
    bit            drain;
  } pend_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  nft_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  nft_pkg::rsp_t rsp;

  number_forwarding_table_unit u_top (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready),
    .req(req), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  always #5 clk = ~clk;

  // Shadow copy of the table state.
  bit            sh_live [N_MAPS];
  bit            sh_used [N_ENTRIES];
  logic [SW-1:0] sh_owner [N_ENTRIES];
  logic [DW-1:0] sh_key [N_ENTRIES];
  logic [LW-1:0] sh_key_len [N_ENTRIES];
  logic [DW-1:0] sh_val [N_ENTRIES];
  logic [LW-1:0] sh_val_len [N_ENTRIES];

  pend_item_t    pending_reqs[$];
  nft_pkg::rsp_t expected_rsps[$];
  int            mismatches = 0;
  int            accepted = 0;
  int            req_idle = 0;
  int            rsp_idle = 0;
  bit            quiet = 1'b0;
  longint        cycles = 0;

  // Keep only the nibbles below the digit count.
  function automatic logic [DW-1:0] trim_digits(logic [DW-1:0] d, logic [LW-1:0] len);
    logic [DW-1:0] m;
    m = '0;
    for (int i = 0; i < 16; i++) if (i < len) m[4*i +: 4] = d[4*i +: 4];
    return m;
  endfunction

  function automatic bit digits_valid(logic [DW-1:0] d, logic [LW-1:0] len);
    bit ok;
    ok = (len >= 1) && (len <= 16);
    for (int i = 0; i < 16; i++) if (i < len && d[4*i +: 4] > 4'd9) ok = 1'b0;
    return ok;
  endfunction

  function automatic int lookup(logic [SW-1:0] m, logic [DW-1:0] k, logic [LW-1:0] len);
    for (int i = 0; i < N_ENTRIES; i++)
      if (sh_used[i] && sh_owner[i] == m && sh_key_len[i] == len && sh_key[i] == k)
        return i;
    return -1;
  endfunction

  // Apply one request to the shadow state and return the response it causes.
  function automatic nft_pkg::rsp_t forward_table_step(nft_pkg::req_t q);
    nft_pkg::rsp_t o;
    logic [DW-1:0] src, dst, cur;
    logic [LW-1:0] clen;
    bit seen [N_ENTRIES];
    int e, f;
    bit live;
    o = '0;
    o.status = nft_pkg::ST_OK;
    src = trim_digits(q.src_digits, q.src_len);
    dst = trim_digits(q.dst_digits, q.dst_len);
    live = sh_live[q.map_slot];
    if (q.mode == nft_pkg::MODE_CREATE) begin
      o.status = nft_pkg::ST_NO_FREE_MAP;
      for (int i = 0; i < N_MAPS; i++) begin
        if (!sh_live[i]) begin
          sh_live[i] = 1'b1;
          o.new_map_slot = SW'(i);
          o.status = nft_pkg::ST_OK;
          break;
        end
      end
    end else if (q.mode > nft_pkg::MODE_TRANSFORM) begin
      // Unknown modes answer with an all-zero result.
    end else if (!live) begin
      o.status = nft_pkg::ST_NO_MAP;
    end else if (q.mode == nft_pkg::MODE_DELETE) begin
      sh_live[q.map_slot] = 1'b0;
      for (int i = 0; i < N_ENTRIES; i++)
        if (sh_used[i] && sh_owner[i] == q.map_slot) sh_used[i] = 1'b0;
    end else if (!digits_valid(src, q.src_len)) begin
      o.status = nft_pkg::ST_BAD_NUM;
    end else if (q.mode == nft_pkg::MODE_INSERT) begin
      if (!digits_valid(dst, q.dst_len)) begin
        o.status = nft_pkg::ST_BAD_NUM;
      end else begin
        e = lookup(q.map_slot, src, q.src_len);
        if (e < 0) begin
          for (int i = 0; i < N_ENTRIES; i++) begin
            if (!sh_used[i]) begin
              e = i;
              break;
            end
          end
        end
        if (e < 0) begin
          o.status = nft_pkg::ST_FULL;
        end else begin
          sh_used[e] = 1'b1;
          sh_owner[e] = q.map_slot;
          sh_key[e] = src;
          sh_key_len[e] = q.src_len;
          sh_val[e] = dst;
          sh_val_len[e] = q.dst_len;
        end
      end
    end else if (q.mode == nft_pkg::MODE_ERASE) begin
      e = lookup(q.map_slot, src, q.src_len);
      if (e >= 0) begin
        sh_used[e] = 1'b0;
        o.was_erased = 1'b1;
      end
    end else begin
      // Follow the chain; a link back into an already followed entry is a cycle.
      cur = src;
      clen = q.src_len;
      foreach (seen[i]) seen[i] = 1'b0;
      for (int s = 0; s <= N_ENTRIES; s++) begin
        e = lookup(q.map_slot, cur, clen);
        if (e < 0) break;
        f = lookup(q.map_slot, sh_val[e], sh_val_len[e]);
        if (f >= 0 && seen[f]) begin
          o.cycle_found = 1'b1;
          cur = src;
          clen = q.src_len;
          break;
        end
        seen[e] = 1'b1;
        cur = sh_val[e];
        clen = sh_val_len[e];
      end
      o.result_digits = cur;
      o.result_len = clen;
    end
    return o;
  endfunction

  // Random number: mostly from a small pool so that entries collide and chain.
  task automatic pick_number(output logic [DW-1:0] d, output logic [LW-1:0] len);
    int p;
    p = $urandom_range(0, 99);
    d = {$urandom, $urandom};
    if (p < 85) begin
      len = LW'($urandom_range(1, 2));
      for (int i = 0; i < 2; i++) d[4*i +: 4] = 4'($urandom_range(0, 3));
    end else if (p < 92) begin
      len = LW'(16);
      for (int i = 0; i < 16; i++) d[4*i +: 4] = 4'($urandom_range(0, 9));
    end else begin
      len = LW'($urandom_range(0, 31));
    end
  endtask

  task automatic queue_req(logic [2:0] m, logic [1:0] s, logic [63:0] sd, logic [4:0] sl,
                           logic [63:0] dd, logic [4:0] dl, bit drain);
    pend_item_t it;
    it.r.mode = m;
    it.r.map_slot = s;
    it.r.src_digits = sd;
    it.r.src_len = sl;
    it.r.dst_digits = dd;
    it.r.dst_len = dl;
    it.drain = drain;
    pending_reqs.push_back(it);
  endtask

  // Request driver: one nonblocking update of valid per edge.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        expected_rsps.push_back(forward_table_step(req));
        accepted++;
        if (!quiet && $urandom_range(0, 4) == 0) req_idle = $urandom_range(1, 18);
      end
      if (!req_valid || req_ready) begin
        if (req_idle > 0) begin
          req_idle--;
          req_valid <= 1'b0;
        end else if (pending_reqs.size() > 0 &&
                     !(pending_reqs[0].drain && (expected_rsps.size() > 0 ||
                       (req_valid && req_ready)))) begin
          req <= pending_reqs[0].r;
          pending_reqs.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor with random stalls of the receiver.
  always @(posedge clk) begin
    nft_pkg::rsp_t x;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected response %p", rsp);
        end else begin
          x = expected_rsps.pop_front();
          if (rsp.new_map_slot !== x.new_map_slot || rsp.result_digits !== x.result_digits ||
              rsp.result_len !== x.result_len || rsp.was_erased !== x.was_erased ||
              rsp.cycle_found !== x.cycle_found || rsp.status !== x.status) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: expected slot %0d digits %h len %0d erased %0b cyc %0b st %0d",
                       x.new_map_slot, x.result_digits, x.result_len, x.was_erased,
                       x.cycle_found, x.status);
              $display("          got slot %0d digits %h len %0d erased %0b cyc %0b st %0d",
                       rsp.new_map_slot, rsp.result_digits, rsp.result_len,
                       rsp.was_erased, rsp.cycle_found, rsp.status);
            end
          end
        end
      end
      if (rsp_idle > 0) begin
        rsp_idle--;
        rsp_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        rsp_idle = $urandom_range(0, 17);
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // Watchdog on the cycle count.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    logic [63:0] sd, dd;
    logic [4:0] sl, dl;
    logic [2:0] m;
    int p;
    foreach (sh_live[i]) sh_live[i] = 1'b0;
    foreach (sh_used[i]) sh_used[i] = 1'b0;

    // Directed: map allocation, bad numbers, chains, cycles and unknown modes.
    queue_req(nft_pkg::MODE_TRANSFORM, 2'd0, 64'h1, 5'd1, 64'h0, 5'd0, 1'b0);
    for (int i = 0; i < 5; i++)
      queue_req(nft_pkg::MODE_CREATE, 2'd3, '1, 5'd31, '1, 5'd31, 1'b0);
    queue_req(nft_pkg::MODE_INSERT, 2'd3, 64'h9999_9999_9999_9999, 5'd16,
              64'hFFFF_FFFF_FFFF_0000, 5'd4, 1'b0);
    queue_req(nft_pkg::MODE_INSERT, 2'd3, 64'h0, 5'd1, 64'h0, 5'd16, 1'b0);
    queue_req(nft_pkg::MODE_INSERT, 2'd0, 64'h1, 5'd0, 64'h2, 5'd1, 1'b0);
    queue_req(nft_pkg::MODE_INSERT, 2'd0, 64'h1, 5'd17, 64'h2, 5'd1, 1'b0);
    queue_req(nft_pkg::MODE_INSERT, 2'd0, 64'hA1, 5'd2, 64'h2, 5'd1, 1'b0);
    queue_req(nft_pkg::MODE_INSERT, 2'd0, 64'h1, 5'd1, 64'hB, 5'd1, 1'b0);
    queue_req(nft_pkg::MODE_INSERT, 2'd0, 64'hFFF1, 5'd1, 64'h2, 5'd1, 1'b0);
    queue_req(nft_pkg::MODE_INSERT, 2'd0, 64'h2, 5'd1, 64'h3, 5'd1, 1'b0);
    queue_req(nft_pkg::MODE_TRANSFORM, 2'd0, 64'h1, 5'd1, 64'h0, 5'd0, 1'b0);
    queue_req(nft_pkg::MODE_INSERT, 2'd0, 64'h3, 5'd1, 64'h1, 5'd1, 1'b0);
    queue_req(nft_pkg::MODE_TRANSFORM, 2'd0, 64'h1, 5'd1, 64'h0, 5'd0, 1'b0);
    queue_req(nft_pkg::MODE_TRANSFORM, 2'd3, 64'h9999_9999_9999_9999, 5'd16,
              64'h0, 5'd0, 1'b0);
    queue_req(nft_pkg::MODE_ERASE, 2'd0, 64'h3, 5'd1, 64'h0, 5'd0, 1'b0);
    queue_req(nft_pkg::MODE_ERASE, 2'd0, 64'h3, 5'd1, 64'h0, 5'd0, 1'b0);
    queue_req(nft_pkg::MODE_ERASE, 2'd0, 64'hC, 5'd1, 64'h0, 5'd0, 1'b0);
    queue_req(nft_pkg::MODE_DELETE, 2'd0, 64'h0, 5'd0, 64'h0, 5'd0, 1'b0);
    queue_req(nft_pkg::MODE_TRANSFORM, 2'd0, 64'h1, 5'd1, 64'h0, 5'd0, 1'b0);
    queue_req(nft_pkg::MODE_DELETE, 2'd0, 64'h0, 5'd0, 64'h0, 5'd0, 1'b0);
    queue_req(3'd5, 2'd1, '1, 5'd31, '1, 5'd31, 1'b0);
    queue_req(3'd6, 2'd2, 64'h1, 5'd1, 64'h1, 5'd1, 1'b0);
    queue_req(3'd7, 2'd3, 64'h0, 5'd0, 64'h0, 5'd0, 1'b1);

    // Random: mostly well-formed work on live maps, some noise.
    for (int n = 0; n < N_RANDOM; n++) begin
      p = $urandom_range(0, 99);
      if (p < 5) m = nft_pkg::MODE_CREATE;
      else if (p < 9) m = nft_pkg::MODE_DELETE;
      else if (p < 50) m = nft_pkg::MODE_INSERT;
      else if (p < 65) m = nft_pkg::MODE_ERASE;
      else if (p < 97) m = nft_pkg::MODE_TRANSFORM;
      else m = 3'($urandom_range(5, 7));
      pick_number(sd, sl);
      pick_number(dd, dl);
      queue_req(m, 2'($urandom_range(0, 3)), sd, sl, dd, dl, (n % 600) == 599);
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    wait (pending_reqs.size() < QUIET_TAIL);
    quiet = 1'b1;
    wait (pending_reqs.size() == 0 && !req_valid);
    wait (expected_rsps.size() == 0);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
